// ----- sv/bpcpid_pkg.sv -----
// Package for the battery power command block with damped PID.
// Holds the transaction types, code constants and datapath sizing.
// No dependencies; imported by battery_power_command_pid.
package bpcpid_pkg;

   // Datapath sizing
   localparam int INTEGRAL_WIDTH     = 40;
   localparam int GAIN_FRACTION_BITS = 8;
   localparam int CHUNK_W            = 32;
   localparam int ICHUNKS            = (INTEGRAL_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int IPAD_W             = ICHUNKS * CHUNK_W;
   localparam int OPA_W              = 17;
   localparam int OPB_W              = CHUNK_W + 1;
   localparam int PROD_W             = OPA_W + OPB_W;
   localparam int ACC_W              = (INTEGRAL_WIDTH + 18 > PROD_W + 2) ?
                                       INTEGRAL_WIDTH + 18 : PROD_W + 2;
   localparam int DIV_W              = 40;
   localparam int DIV_BITS_PER_STEP  = 4;
   localparam int DIV_STEPS          = DIV_W / DIV_BITS_PER_STEP;
   localparam int CNT_W              = $clog2(DIV_STEPS + 1);
   localparam int ERR_W              = 20;
   localparam int Y_W                = 32;

   // Fixed constants
   localparam logic [6:0]  PCT_FULL   = 7'd100;
   localparam logic [7:0]  DIVISOR    = 8'd100;
   localparam logic [5:0]  ROUND_HALF = 6'd50;
   localparam logic [13:0] PV_LIMIT   = 14'd10000;
   localparam logic [15:0] POWER_MAX  = 16'hFFFF;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_GRID_POWER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P            = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I            = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D            = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_DAMPING    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_DAMPING     = 3'd6;

   // Strategy codes
   localparam logic [2:0] MODE_STOP   = 3'd0;
   localparam logic [2:0] MODE_SELF   = 3'd1;
   localparam logic [2:0] MODE_CHARGE = 3'd2;
   localparam logic [2:0] MODE_PV     = 3'd3;
   localparam logic [2:0] MODE_SELL   = 3'd4;

   // Stop criteria
   localparam logic [1:0] GOAL_NONE   = 2'd0;
   localparam logic [1:0] GOAL_SOC    = 2'd1;
   localparam logic [1:0] GOAL_ENERGY = 2'd2;

   // Commands
   localparam logic [1:0] CMD_STOP      = 2'd0;
   localparam logic [1:0] CMD_CHARGE    = 2'd1;
   localparam logic [1:0] CMD_DISCHARGE = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] grid_power;
      logic [21:0]        total_energy;
      logic [9:0]         avg_charge_level;
      logic [15:0]        goal_power;
      logic [9:0]         goal_charge_level;
      logic [21:0]        goal_energy;
      logic [1:0]         goal_kind;
   } req_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] power_watts;
      logic        clipped;
   } rsp_type;

endpackage

// ----- sv/battery_power_command_pid.sv -----
// Battery power command: one command per request from the active strategy.
// Self-consumption runs a damped PID on a shared multiply-accumulate unit.
// Depends on bpcpid_pkg.

// Usage: each request returns one response (stop, charge or discharge with a
// power in watts). Stop, charge, sell and charge-from-PV requests go from
// acceptance straight to the final step that loads the response register. A
// self-consumption request first runs the damped PID: the PID terms go one
// product per cycle through the single 17x33 multiplier with its accumulator,
// and each of the two round-to-nearest divisions by 100 runs through a divide
// unit that retires 4 quotient bits per cycle. req_stall is high from
// acceptance until the response is loaded; a response waiting on rsp_stall
// holds the sequencer in its last step. The configuration port is always
// ready and must only be written while idle.
module battery_power_command_pid
   import bpcpid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ISUM_W = INTEGRAL_WIDTH + 1;
   localparam int QS_W   = DIV_W + 1;
   localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
   localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
   localparam logic signed [Y_W-1:0]   Y_MAX   = {1'b0, {(Y_W-1){1'b1}}};
   localparam logic signed [Y_W-1:0]   Y_MIN   = {1'b1, {(Y_W-1){1'b0}}};
   localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MAX =
      {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
   localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MIN =
      {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

   typedef enum logic [12:0] {
      ST_IDLE  = 13'h0001,
      ST_ERR0  = 13'h0002,
      ST_ERR1  = 13'h0004,
      ST_DLOAD = 13'h0008,
      ST_DIV   = 13'h0010,
      ST_INTEG = 13'h0020,
      ST_MI    = 13'h0040,
      ST_MP    = 13'h0080,
      ST_MD    = 13'h0100,
      ST_USAT  = 13'h0200,
      ST_Y0    = 13'h0400,
      ST_Y1    = 13'h0800,
      ST_FIN   = 13'h1000
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SHIFT_ADD
   } acc_op_type;

   // Control and persistent state
   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        phase_ff, phase_in;
   logic signed [14:0]          tgp_ff, tgp_in;
   logic [13:0]                 deadband_ff, deadband_in;
   logic signed [15:0]          gain_p_ff, gain_p_in;
   logic signed [15:0]          gain_i_ff, gain_i_in;
   logic signed [15:0]          gain_d_ff, gain_d_in;
   logic [6:0]                  out_damp_ff, out_damp_in;
   logic [6:0]                  err_damp_ff, err_damp_in;
   logic signed [ERR_W-1:0]     lde_ff, lde_in;
   logic signed [INTEGRAL_WIDTH-1:0] integ_ff, integ_in;
   logic signed [Y_W-1:0]       ldo_ff, ldo_in;

   // Datapath registers
   req_type                     item_ff, item_in;
   rsp_type                     rsp_ff, rsp_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic [DIV_W-1:0]            div_ff, div_in;
   logic [6:0]                  rem_ff, rem_in;
   logic                        neg_ff, neg_in;
   logic signed [ERR_W-1:0]     de_ff, de_in;
   logic signed [Y_W-1:0]       u_ff, u_in;
   logic [IPAD_W-1:0]           ishift_ff, ishift_in;

   // Combinational helpers
   logic [6:0]                  ed_eff, od_eff;
   logic signed [16:0]          err_e;
   logic signed [20:0]          d_diff;
   logic signed [OPA_W-1:0]     op_a;
   logic signed [OPB_W-1:0]     op_b;
   logic signed [PROD_W-1:0]    prod;
   logic signed [ACC_W-1:0]     prod_x;
   acc_op_type                  acc_op;
   logic [ACC_W-1:0]            acc_abs;
   logic [DIV_W-1:0]            div_step;
   logic [6:0]                  rem_step;
   logic signed [DIV_W:0]       quo_mag;
   logic signed [QS_W-1:0]      quo_s;
   logic signed [ERR_W-1:0]     de_sat;
   logic signed [Y_W-1:0]       y_sat;
   logic signed [ISUM_W-1:0]    isum;
   logic signed [INTEGRAL_WIDTH-1:0] isat;
   logic signed [ACC_W-1:0]     ash;
   logic signed [Y_W-1:0]       u_sat;
   logic [CHUNK_W-1:0]          chunk_top;
   logic                        mi_first;
   logic                        req_take;
   logic                        fin_fire;
   logic                        item_pid;
   logic                        acc_mode_pid;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign fin_fire    = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   // Decode self-consumption, including unused codes
   always_comb begin
      acc_mode_pid = !(req_payload.mode == MODE_STOP || req_payload.mode == MODE_CHARGE ||
                       req_payload.mode == MODE_PV || req_payload.mode == MODE_SELL);
      item_pid     = !(item_ff.mode == MODE_STOP || item_ff.mode == MODE_CHARGE ||
                       item_ff.mode == MODE_PV || item_ff.mode == MODE_SELL);
   end

   // Configuration writes
   always_comb begin
      tgp_in      = tgp_ff;
      deadband_in = deadband_ff;
      gain_p_in   = gain_p_ff;
      gain_i_in   = gain_i_ff;
      gain_d_in   = gain_d_ff;
      out_damp_in = out_damp_ff;
      err_damp_in = err_damp_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TARGET_GRID_POWER: tgp_in      = csr_data[14:0];
            CSR_DEADBAND:          deadband_in = csr_data[13:0];
            CSR_GAIN_P:            gain_p_in   = csr_data;
            CSR_GAIN_I:            gain_i_in   = csr_data;
            CSR_GAIN_D:            gain_d_in   = csr_data;
            CSR_OUTPUT_DAMPING:    out_damp_in = csr_data[6:0];
            CSR_ERROR_DAMPING:     err_damp_in = csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Clamp damping percentages and form the raw error and derivative
   always_comb begin
      ed_eff    = (err_damp_ff > PCT_FULL) ? PCT_FULL : err_damp_ff;
      od_eff    = (out_damp_ff > PCT_FULL) ? PCT_FULL : out_damp_ff;
      err_e     = 17'(item_ff.grid_power) - 17'(tgp_ff);
      d_diff    = 21'(de_ff) - 21'(lde_ff);
      chunk_top = ishift_ff[IPAD_W-1 -: CHUNK_W];
      mi_first  = (cnt_ff == CNT_W'(ICHUNKS - 1));
   end

   // Select multiplier operands and accumulator operation per step
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      acc_op = ACC_HOLD;
      unique case (state_ff)
         ST_ERR0: begin
            op_a   = OPA_W'(PCT_FULL - ed_eff);
            op_b   = OPB_W'(err_e);
            acc_op = ACC_LOAD;
         end
         ST_ERR1: begin
            op_a   = OPA_W'(ed_eff);
            op_b   = OPB_W'(lde_ff);
            acc_op = ACC_ADD;
         end
         ST_MI: begin
            op_a = OPA_W'(gain_i_ff);
            if (mi_first) begin
               op_b   = OPB_W'($signed(chunk_top));
               acc_op = ACC_LOAD;
            end else begin
               op_b   = OPB_W'(chunk_top);
               acc_op = ACC_SHIFT_ADD;
            end
         end
         ST_MP: begin
            op_a   = OPA_W'(gain_p_ff);
            op_b   = OPB_W'(de_ff);
            acc_op = ACC_ADD;
         end
         ST_MD: begin
            op_a   = OPA_W'(gain_d_ff);
            op_b   = OPB_W'(d_diff);
            acc_op = ACC_ADD;
         end
         ST_Y0: begin
            op_a   = OPA_W'(PCT_FULL - od_eff);
            op_b   = OPB_W'(u_ff);
            acc_op = ACC_LOAD;
         end
         ST_Y1: begin
            op_a   = OPA_W'(od_eff);
            op_b   = OPB_W'(ldo_ff);
            acc_op = ACC_ADD;
         end
         default: acc_op = ACC_HOLD;
      endcase
   end

   // Shared multiply-accumulate unit
   always_comb begin
      prod   = PROD_W'(op_a) * PROD_W'(op_b);
      prod_x = ACC_W'(prod);
      unique case (acc_op)
         ACC_LOAD:      acc_in = prod_x;
         ACC_ADD:       acc_in = acc_ff + prod_x;
         ACC_SHIFT_ADD: acc_in = (acc_ff <<< CHUNK_W) + prod_x;
         default:       acc_in = acc_ff;
      endcase
   end

   // Divide-by-100 unit: restoring, several quotient bits per cycle
   always_comb begin
      logic [7:0] r8;
      div_step = div_ff;
      rem_step = rem_ff;
      for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
         r8       = {rem_step, div_step[DIV_W-1]};
         div_step = {div_step[DIV_W-2:0], 1'b0};
         if (r8 >= DIVISOR) begin
            rem_step    = 7'(r8 - DIVISOR);
            div_step[0] = 1'b1;
         end else begin
            rem_step = r8[6:0];
         end
      end
      acc_abs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      quo_mag = $signed({1'b0, div_ff});
      quo_s   = neg_ff ? -quo_mag : quo_mag;
   end

   // Saturate the divide results, the integral and the scaled PID sum
   always_comb begin
      if (quo_s > QS_W'(ERR_MAX)) begin
         de_sat = ERR_MAX;
      end else if (quo_s < QS_W'(ERR_MIN)) begin
         de_sat = ERR_MIN;
      end else begin
         de_sat = quo_s[ERR_W-1:0];
      end

      if (quo_s > QS_W'(Y_MAX)) begin
         y_sat = Y_MAX;
      end else if (quo_s < QS_W'(Y_MIN)) begin
         y_sat = Y_MIN;
      end else begin
         y_sat = quo_s[Y_W-1:0];
      end

      isum = ISUM_W'(integ_ff) + ISUM_W'(de_sat);
      if (isum > ISUM_W'(INT_MAX)) begin
         isat = INT_MAX;
      end else if (isum < ISUM_W'(INT_MIN)) begin
         isat = INT_MIN;
      end else begin
         isat = isum[INTEGRAL_WIDTH-1:0];
      end

      ash = acc_ff >>> GAIN_FRACTION_BITS;
      if (ash > ACC_W'(Y_MAX)) begin
         u_sat = Y_MAX;
      end else if (ash < ACC_W'(Y_MIN)) begin
         u_sat = Y_MIN;
      end else begin
         u_sat = ash[Y_W-1:0];
      end
   end

   // Build the response for the held transaction
   always_comb begin
      logic               stop_goal;
      logic signed [16:0] g17;
      logic signed [16:0] db17;
      logic signed [16:0] pv_p;
      logic signed [32:0] y33;
      logic signed [32:0] db33;
      logic signed [32:0] mag;
      rsp_in.command     = CMD_STOP;
      rsp_in.power_watts = '0;
      rsp_in.clipped     = 1'b0;
      stop_goal          = 1'b0;
      g17                = 17'(item_ff.grid_power);
      db17               = $signed(17'(deadband_ff));
      pv_p               = -g17;
      y33                = 33'(y_sat);
      db33               = $signed(33'(deadband_ff));
      mag                = y33[32] ? -y33 : y33;
      unique case (item_ff.mode)
         MODE_STOP: rsp_in.command = CMD_STOP;
         MODE_CHARGE, MODE_SELL: begin
            if (item_ff.mode == MODE_CHARGE) begin
               if (item_ff.goal_kind == GOAL_SOC) begin
                  stop_goal = item_ff.avg_charge_level >= item_ff.goal_charge_level;
               end else if (item_ff.goal_kind == GOAL_ENERGY) begin
                  stop_goal = item_ff.total_energy >= item_ff.goal_energy;
               end
            end else begin
               if (item_ff.goal_kind == GOAL_SOC) begin
                  stop_goal = item_ff.avg_charge_level <= item_ff.goal_charge_level;
               end else if (item_ff.goal_kind == GOAL_ENERGY) begin
                  stop_goal = item_ff.total_energy <= item_ff.goal_energy;
               end
            end
            if (!stop_goal) begin
               rsp_in.command     = (item_ff.mode == MODE_CHARGE) ? CMD_CHARGE : CMD_DISCHARGE;
               rsp_in.power_watts = item_ff.goal_power;
            end
         end
         MODE_PV: begin
            if (g17 < -db17) begin
               rsp_in.command = CMD_CHARGE;
               if (pv_p > $signed(17'(PV_LIMIT))) begin
                  rsp_in.power_watts = 16'(PV_LIMIT);
               end else begin
                  rsp_in.power_watts = pv_p[15:0];
               end
            end
         end
         default: begin
            // Self-consumption: deadband, direction and magnitude clip
            if (y33 > db33 || y33 < -db33) begin
               rsp_in.command = y33[32] ? CMD_CHARGE : CMD_DISCHARGE;
               if (mag > $signed(33'(POWER_MAX))) begin
                  rsp_in.power_watts = POWER_MAX;
                  rsp_in.clipped     = 1'b1;
               end else begin
                  rsp_in.power_watts = mag[15:0];
               end
            end
         end
      endcase
   end

   // Sequencer and register next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      item_in      = item_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      de_in        = de_ff;
      u_in         = u_ff;
      ishift_in    = ishift_ff;
      lde_in       = lde_ff;
      integ_in     = integ_ff;
      ldo_in       = ldo_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in  = req_payload;
               phase_in = 1'b0;
               state_in = acc_mode_pid ? ST_ERR0 : ST_FIN;
            end
         end
         ST_ERR0: state_in = ST_ERR1;
         ST_ERR1: state_in = ST_DLOAD;
         ST_DLOAD: begin
            neg_in   = acc_ff[ACC_W-1];
            div_in   = acc_abs[DIV_W-1:0] + DIV_W'(ROUND_HALF);
            rem_in   = '0;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_in = div_step;
            rem_in = rem_step;
            if (cnt_ff == '0) begin
               state_in = phase_ff ? ST_FIN : ST_INTEG;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_INTEG: begin
            de_in     = de_sat;
            integ_in  = isat;
            ishift_in = IPAD_W'(isat);
            cnt_in    = CNT_W'(ICHUNKS - 1);
            state_in  = ST_MI;
         end
         ST_MI: begin
            ishift_in = ishift_ff << CHUNK_W;
            if (cnt_ff == '0) begin
               state_in = ST_MP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MP:   state_in = ST_MD;
         ST_MD:   state_in = ST_USAT;
         ST_USAT: begin
            u_in     = u_sat;
            state_in = ST_Y0;
         end
         ST_Y0:   state_in = ST_Y1;
         ST_Y1: begin
            phase_in = 1'b1;
            state_in = ST_DLOAD;
         end
         ST_FIN: begin
            if (fin_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (item_pid) begin
                  lde_in = de_ff;
                  ldo_in = y_sat;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and persistent state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         tgp_ff       <= '0;
         deadband_ff  <= '0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         out_damp_ff  <= '0;
         err_damp_ff  <= '0;
         lde_ff       <= '0;
         integ_ff     <= '0;
         ldo_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         tgp_ff       <= tgp_in;
         deadband_ff  <= deadband_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         out_damp_ff  <= out_damp_in;
         err_damp_ff  <= err_damp_in;
         lde_ff       <= lde_in;
         integ_ff     <= integ_in;
         ldo_ff       <= ldo_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      acc_ff    <= acc_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      de_ff     <= de_in;
      u_ff      <= u_in;
      ishift_ff <= ishift_in;
      if (fin_fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // A new response is only loaded from the final step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the final step");

   // An accepted transaction keeps the input stalled on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after acceptance");

   // A stop response carries no power and no clip flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.command == CMD_STOP) |->
      (rsp_payload.power_watts == '0 && !rsp_payload.clipped))
      else $error("stop response with nonzero power or clip");

   // Clip flag implies full-scale power
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.clipped) |-> (rsp_payload.power_watts == POWER_MAX))
      else $error("clipped response below full scale");
`endif

endmodule

// ----- tb/tb_battery_power_command_pid.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for battery_power_command_pid: strategy dispatch and damped PID.
// Drives requests and CSR writes and checks every response against a predictor in this file.
// Depends on bpcpid_pkg and the battery_power_command_pid RTL.
module tb_battery_power_command_pid;
   import bpcpid_pkg::*;

   localparam longint ERR_HI = (64'sd1 <<< (ERR_W - 1)) - 1;
   localparam longint ERR_LO = -(64'sd1 <<< (ERR_W - 1));
   localparam longint OUT_HI = (64'sd1 <<< (Y_W - 1)) - 1;
   localparam longint OUT_LO = -(64'sd1 <<< (Y_W - 1));
   localparam longint INT_HI = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1;
   localparam longint INT_LO = -(64'sd1 <<< (INTEGRAL_WIDTH - 1));
   localparam longint PRODUCT_LIMIT = 64'sd1 <<< 47;
   localparam int     SETTLE_CYCLES = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Predictor copy of the settings
   longint set_target = 0;
   longint set_deadband = 0;
   longint set_kp = 0;
   longint set_ki = 0;
   longint set_kd = 0;
   longint set_out_damp = 0;
   longint set_err_damp = 0;

   // Predictor copy of the PID state
   longint damped_err_q = 0;
   longint integ_q = 0;
   longint damped_out_q = 0;

   rsp_type expected_commands[$];
   int      mismatch_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      grid_walk = 0;

   battery_power_command_pid DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Divide by 100, round to nearest with ties away from zero
   function automatic longint round_div_hundred(longint x);
      if (x >= 0) begin
         return (x + 50) / 100;
      end
      return -((-x + 50) / 100);
   endfunction

   // Track a register write in the predictor
   function automatic void apply_setting(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_TARGET_GRID_POWER: set_target = $signed(v[14:0]);
         CSR_DEADBAND:          set_deadband = v[13:0];
         CSR_GAIN_P:            set_kp = $signed(v);
         CSR_GAIN_I:            set_ki = $signed(v);
         CSR_GAIN_D:            set_kd = $signed(v);
         CSR_OUTPUT_DAMPING:    set_out_damp = v[6:0];
         CSR_ERROR_DAMPING:     set_err_damp = v[6:0];
         default: ;
      endcase
   endfunction

   // Compute the command for one request and advance the PID state
   function automatic rsp_type predict_command(req_type r);
      longint  grid, ed, od, e, de, d, ic, sum, u, y, mag;
      logic    halt;
      rsp_type res;
      res = '0;
      res.command = CMD_STOP;
      grid = $signed(r.grid_power);
      case (r.mode)
         MODE_STOP: ;
         MODE_CHARGE, MODE_SELL: begin
            halt = 1'b0;
            if (r.goal_kind == GOAL_SOC) begin
               halt = (r.mode == MODE_CHARGE) ? (r.avg_charge_level >= r.goal_charge_level)
                                              : (r.avg_charge_level <= r.goal_charge_level);
            end else if (r.goal_kind == GOAL_ENERGY) begin
               halt = (r.mode == MODE_CHARGE) ? (r.total_energy >= r.goal_energy)
                                              : (r.total_energy <= r.goal_energy);
            end
            if (!halt) begin
               res.command = (r.mode == MODE_CHARGE) ? CMD_CHARGE : CMD_DISCHARGE;
               res.power_watts = r.goal_power;
            end
         end
         MODE_PV: begin
            if (grid < -set_deadband) begin
               mag = (-grid > longint'(PV_LIMIT)) ? longint'(PV_LIMIT) : -grid;
               res.command = CMD_CHARGE;
               res.power_watts = mag[15:0];
            end
         end
         default: begin
            // Self-consumption, also taken by the unused codes
            ed = (set_err_damp > 100) ? 100 : set_err_damp;
            od = (set_out_damp > 100) ? 100 : set_out_damp;
            e = grid - set_target;
            de = clamp_to(round_div_hundred(e * (100 - ed) + damped_err_q * ed), ERR_LO, ERR_HI);
            integ_q = clamp_to(integ_q + de, INT_LO, INT_HI);
            d = de - damped_err_q;
            ic = clamp_to(integ_q, -PRODUCT_LIMIT, PRODUCT_LIMIT);
            sum = set_kp * de + set_ki * ic + set_kd * d;
            u = clamp_to(sum >>> GAIN_FRACTION_BITS, OUT_LO, OUT_HI);
            y = clamp_to(round_div_hundred(u * (100 - od) + damped_out_q * od), OUT_LO, OUT_HI);
            damped_err_q = de;
            damped_out_q = y;
            if (y > set_deadband || y < -set_deadband) begin
               mag = (y > 0) ? y : -y;
               res.command = (y > 0) ? CMD_DISCHARGE : CMD_CHARGE;
               if (mag > longint'(POWER_MAX)) begin
                  mag = POWER_MAX;
                  res.clipped = 1'b1;
               end
               res.power_watts = mag[15:0];
            end
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_request(logic [2:0] m, int grid, int energy, int soc,
                                            int gpow, int gsoc, int genergy, logic [1:0] kind);
      req_type r;
      r.mode = m;
      r.grid_power = grid[15:0];
      r.total_energy = energy[21:0];
      r.avg_charge_level = soc[9:0];
      r.goal_power = gpow[15:0];
      r.goal_charge_level = gsoc[9:0];
      r.goal_energy = genergy[21:0];
      r.goal_kind = kind;
      return r;
   endfunction

   // Mostly slowly moving grid power for the PID, with other strategies and noise mixed in
   function automatic req_type random_request();
      req_type r;
      int      roll, grid, energy;
      roll = $urandom_range(0, 99);
      if (roll < 50) r.mode = MODE_SELF;
      else if (roll < 55) r.mode = 3'($urandom_range(5, 7));
      else if (roll < 65) r.mode = MODE_CHARGE;
      else if (roll < 75) r.mode = MODE_SELL;
      else if (roll < 88) r.mode = MODE_PV;
      else if (roll < 94) r.mode = MODE_STOP;
      else r.mode = 3'($urandom_range(0, 7));
      roll = $urandom_range(0, 99);
      if (r.mode != MODE_CHARGE && r.mode != MODE_SELL && r.mode != MODE_PV &&
          r.mode != MODE_STOP && roll < 70) begin
         grid_walk = int'(clamp_to(grid_walk + int'($urandom_range(0, 400)) - 200,
                                   -30000, 30000));
         grid = grid_walk;
      end else if (roll < 85) begin
         grid = int'($urandom_range(0, 4000)) - 2000;
      end else begin
         grid = $urandom_range(0, 65535);
      end
      r.grid_power = grid[15:0];
      energy = $urandom_range(0, 4194303);
      r.total_energy = energy[21:0];
      if ($urandom_range(0, 1) == 0) begin
         r.goal_energy = 22'(energy + int'($urandom_range(0, 8)) - 4);
      end else begin
         r.goal_energy = 22'($urandom_range(0, 4194303));
      end
      r.avg_charge_level = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                       : 10'($urandom_range(0, 1000));
      r.goal_charge_level = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                        : 10'($urandom_range(0, 1000));
      r.goal_power = 16'($urandom_range(0, 65535));
      r.goal_kind = 2'($urandom_range(0, 3));
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Send one request and record its expected command on acceptance
   task automatic issue_request(input req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_commands.push_back(predict_command(r));
   endtask

   // Hold off the sender at random before the next request
   task automatic sender_gap();
      if ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 40)) @(negedge clock);
      end
   endtask

   task automatic write_setting(input logic [CSR_INDEX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_setting(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every outstanding response, then let the block settle
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Randomize the receiver stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Compare each accepted response with the oldest expected command
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_commands.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_commands.pop_front();
            if (rsp_payload.command !== want.command)
               report_mismatch($sformatf("command %0d, expected %0d",
                                         rsp_payload.command, want.command));
            if (rsp_payload.power_watts !== want.power_watts)
               report_mismatch($sformatf("power_watts %0d, expected %0d",
                                         rsp_payload.power_watts, want.power_watts));
            if (rsp_payload.clipped !== want.clipped)
               report_mismatch($sformatf("clipped %0b, expected %0b",
                                         rsp_payload.clipped, want.clipped));
         end
      end
   end

   // Stop criteria, charge-from-PV limits and the unused strategy codes
   task automatic test_strategy_codes();
      write_setting(CSR_DEADBAND, 16'd100);
      issue_request(make_request(MODE_STOP, 32767, 4194303, 1023, 65535, 1023, 4194303, 2'd3));
      issue_request(make_request(MODE_CHARGE, 0, 0, 0, 65535, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_CHARGE, 0, 0, 500, 2000, 500, 0, GOAL_SOC));
      issue_request(make_request(MODE_CHARGE, 0, 0, 499, 1234, 500, 0, GOAL_SOC));
      issue_request(make_request(MODE_CHARGE, 0, 4194303, 0, 3000, 0, 4194303, GOAL_ENERGY));
      issue_request(make_request(MODE_CHARGE, 0, 0, 0, 3000, 0, 1, GOAL_ENERGY));
      issue_request(make_request(MODE_CHARGE, 0, 0, 1023, 0, 0, 0, 2'd3));
      issue_request(make_request(MODE_SELL, 0, 0, 500, 2500, 500, 0, GOAL_SOC));
      issue_request(make_request(MODE_SELL, 0, 0, 1000, 2500, 0, 0, GOAL_SOC));
      issue_request(make_request(MODE_SELL, 0, 10, 0, 4000, 0, 9, GOAL_ENERGY));
      issue_request(make_request(MODE_SELL, 0, 9, 0, 4000, 0, 9, GOAL_ENERGY));
      issue_request(make_request(MODE_SELL, 0, 0, 0, 65535, 1023, 4194303, 2'd3));
      issue_request(make_request(MODE_PV, -32768, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_PV, -100, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_PV, -101, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_PV, 32767, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(3'd5, 1500, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(3'd7, -1500, 0, 0, 0, 0, 0, GOAL_NONE));
      wait_for_results();
   endtask

   // Extreme gains, targets and damping, including percentages above one hundred
   task automatic test_pid_extremes();
      write_setting(CSR_DEADBAND, 16'd0);
      write_setting(CSR_TARGET_GRID_POWER, 16'h3FFF);
      write_setting(CSR_GAIN_P, 16'h7FFF);
      issue_request(make_request(MODE_SELF, 32767, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_SELF, -32768, 0, 0, 0, 0, 0, GOAL_NONE));
      wait_for_results();
      write_setting(CSR_TARGET_GRID_POWER, 16'h4000);
      write_setting(CSR_GAIN_P, 16'h8000);
      write_setting(CSR_GAIN_I, 16'h8000);
      write_setting(CSR_GAIN_D, 16'h7FFF);
      write_setting(CSR_OUTPUT_DAMPING, 16'd127);
      write_setting(CSR_ERROR_DAMPING, 16'd127);
      issue_request(make_request(MODE_SELF, 20000, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_SELF, -20000, 0, 0, 0, 0, 0, GOAL_NONE));
      wait_for_results();
      write_setting(CSR_OUTPUT_DAMPING, 16'd100);
      write_setting(CSR_ERROR_DAMPING, 16'd0);
      write_setting(CSR_DEADBAND, 16'h3FFF);
      issue_request(make_request(MODE_SELF, 100, 0, 0, 0, 0, 0, GOAL_NONE));
      wait_for_results();
      write_setting(CSR_TARGET_GRID_POWER, 16'd0);
      write_setting(CSR_GAIN_P, 16'd256);
      write_setting(CSR_GAIN_I, 16'd0);
      write_setting(CSR_GAIN_D, 16'd0);
      write_setting(CSR_OUTPUT_DAMPING, 16'd50);
      write_setting(CSR_ERROR_DAMPING, 16'd50);
      write_setting(CSR_DEADBAND, 16'd0);
      issue_request(make_request(MODE_SELF, 400, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_SELF, -400, 0, 0, 0, 0, 0, GOAL_NONE));
      issue_request(make_request(MODE_SELF, 0, 0, 0, 0, 0, 0, GOAL_NONE));
      wait_for_results();
   endtask

   // Load a fresh random setting into every register
   task automatic program_random_settings();
      int v;
      v = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 4000)) - 2000
                                     : int'($urandom_range(0, 32767));
      write_setting(CSR_TARGET_GRID_POWER, v[15:0]);
      case ($urandom_range(0, 9))
         0, 1:    v = 0;
         2, 3, 4: v = $urandom_range(0, 16383);
         default: v = $urandom_range(0, 500);
      endcase
      write_setting(CSR_DEADBAND, v[15:0]);
      v = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 1024)) - 512
                                     : int'($urandom_range(0, 65535));
      write_setting(CSR_GAIN_P, v[15:0]);
      v = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 128)) - 64
                                     : int'($urandom_range(0, 65535));
      write_setting(CSR_GAIN_I, v[15:0]);
      v = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 1024)) - 512
                                     : int'($urandom_range(0, 65535));
      write_setting(CSR_GAIN_D, v[15:0]);
      case ($urandom_range(0, 9))
         0:       v = 0;
         1:       v = $urandom_range(101, 127);
         default: v = $urandom_range(0, 100);
      endcase
      write_setting(CSR_OUTPUT_DAMPING, v[15:0]);
      case ($urandom_range(0, 9))
         0:       v = 0;
         1:       v = $urandom_range(101, 127);
         default: v = $urandom_range(0, 100);
      endcase
      write_setting(CSR_ERROR_DAMPING, v[15:0]);
   endtask

   // Random traffic in phases, each with its own setting and idle pattern
   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         program_random_settings();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         for (int n = 0; n < 119; n++) begin
            // Now and then hold the sender until the block has answered everything
            if ($urandom_range(0, 99) == 0) wait_for_results();
            sender_gap();
            issue_request(random_request());
         end
         wait_for_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_strategy_codes();
      test_pid_extremes();
      test_random_phases();
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- battery_power_command_pid.f -----
sv/bpcpid_pkg.sv
sv/battery_power_command_pid.sv
tb/tb_battery_power_command_pid.sv
